// File: rtl/pts_pkg.sv
package pts_pkg;

	localparam int THREADS = 64;
	localparam int LEVELS = 3;
	localparam int TID_W = $clog2(THREADS);
	localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PRIO_W = 2;
	localparam int QUANT_W = 16;
	localparam int DATA_W = 16;

	typedef logic [TID_W-1:0] tid_t;
	typedef logic [PRIO_W-1:0] prio_t;
	typedef logic [LVL_W-1:0] lvl_t;
	typedef logic [QUANT_W-1:0] quant_t;

	localparam quant_t QUANTUM_RESET = quant_t'(10000);
	localparam prio_t PRIO_MAX = prio_t'(LEVELS - 1);
	localparam prio_t PRIO_THREAD0 = prio_t'(1 % LEVELS);

	typedef enum logic [2:0] {
		MODE_CREATE  = 3'd0,
		MODE_ENQUEUE = 3'd1,
		MODE_TICK    = 3'd2,
		MODE_YIELD   = 3'd3,
		MODE_BLOCK   = 3'd4,
		MODE_SIGNAL  = 3'd5,
		MODE_EXIT    = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		TS_RUN  = 2'd0,
		TS_BLK  = 2'd1,
		TS_BLKI = 2'd2,
		TS_DEAD = 2'd3
	} thr_state_t;

	typedef enum logic [1:0] {
		RS_DONE    = 2'd0,
		RS_IGNORED = 2'd1,
		RS_BUSY    = 2'd2,
		RS_IDLE    = 2'd3
	} res_status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_DISP
	} fsm_t;

	typedef struct packed {
		thr_state_t status;
		prio_t      prio;
		logic       sig;
		logic       inq;
	} thr_entry_t;

	typedef struct packed {
		logic       rd_en;
		tid_t       rd_addr;
		logic       wr_en;
		tid_t       wr_addr;
		thr_entry_t wr_data;
	} thr_req_t;

	typedef struct packed {
		logic rd_en;
		tid_t rd_addr;
		logic wr_en;
		tid_t wr_addr;
		tid_t wr_data;
	} link_req_t;

endpackage

// File: rtl/priority_thread_scheduler.sv
// channel   | direction | fields (low bit up)
// s_*       | in        | tuser: mode[2:0]; tdata: thread_id[5:0], priority_req[7:6],
//           |           | run_now[8], interruptible[9], is_signal_event[10]
// m_*       | out       | tdata: running_thread[5:0], running_valid[6], switched[7],
//           |           | status[9:8], woken_by_signal[10]
// cfg_*     | in        | quantum_ticks[15:0], written whenever cfg_wr_en is high
//
// an item is accepted in the idle state, where its thread entry is read; the event is
// applied in the exec state, and a dispatch adds the disp state, which uses the link and
// thread memory reads of the head; a new item is accepted only back in the idle state.
// reset clears the per-entry valid bits at once; there is no clearing pass.
// a result waiting in the output register and not yet taken stalls the exec and
// disp states, also when the event dispatches and writes no result of its own.
module priority_thread_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // thread_id, priority_req, run_now, interruptible,
	                               // is_signal_event, zero pad
	input  logic [2:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // running_thread, running_valid, switched, status,
	                               // woken_by_signal, zero pad
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	pts_pkg::fsm_t state_q, state_n;

	// event registers
	logic [2:0] ev_mode_q;
	pts_pkg::tid_t ev_tid_q;
	pts_pkg::prio_t ev_prio_q;
	logic ev_run_q, ev_intr_q, ev_sig_q;
	pts_pkg::prio_t prio_in;

	// running thread and queues
	pts_pkg::tid_t cur_q;
	logic cv_q;
	pts_pkg::thr_state_t cur_status_q;
	pts_pkg::prio_t cur_prio_q;
	logic cur_sig_q;
	pts_pkg::quant_t ticks_q, quantum_q;
	pts_pkg::tid_t head_q [pts_pkg::LEVELS];
	pts_pkg::tid_t tail_q [pts_pkg::LEVELS];
	logic [pts_pkg::LEVELS-1:0] ne_q;

	// dispatch hand-over
	pts_pkg::lvl_t dlv_q;
	pts_pkg::tid_t dh_q;
	logic fwd_link_q, fwd_thr_q;
	pts_pkg::tid_t fwd_link_val_q;
	pts_pkg::thr_entry_t fwd_thr_val_q;

	// output register
	logic out_vld_q;
	pts_pkg::tid_t out_thread_q;
	logic out_run_q, out_sw_q, out_sig_q;
	pts_pkg::res_status_t out_status_q;

	// memory ports
	pts_pkg::thr_req_t thr_req;
	pts_pkg::thr_entry_t thr_rdata;
	pts_pkg::link_req_t link_req;
	pts_pkg::tid_t link_rdata;

	// event logic
	logic busy_c;
	pts_pkg::res_status_t st_c;
	logic thr_we_c;
	pts_pkg::tid_t thr_wa_c;
	pts_pkg::thr_entry_t thr_wd_c;
	pts_pkg::thr_entry_t cur_e;
	logic push_c;
	pts_pkg::tid_t push_tid_c;
	pts_pkg::prio_t push_prio_c;
	pts_pkg::lvl_t push_lv;
	logic disp_c, disp_ok, tick_dec_c;
	logic [pts_pkg::LEVELS-1:0] ne_n;
	pts_pkg::tid_t head_n [pts_pkg::LEVELS];
	pts_pkg::tid_t tail_n [pts_pkg::LEVELS];
	logic link_we_c;
	pts_pkg::tid_t link_wa_c;
	pts_pkg::lvl_t sel_lv;
	pts_pkg::tid_t sel_head;
	logic cv_fin;
	pts_pkg::res_status_t st_fin;
	pts_pkg::thr_entry_t disp_e;
	pts_pkg::tid_t disp_next;

	logic accept, out_free, exec_go, disp_go;

	assign prio_in = (int'(s_tdata[7:6]) >= pts_pkg::LEVELS) ? pts_pkg::PRIO_MAX : s_tdata[7:6];
	assign out_free = !out_vld_q || m_tready;

	pts_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.thr_req    (thr_req),
		.thr_rdata  (thr_rdata),
		.link_req   (link_req),
		.link_rdata (link_rdata)
	);

	always_comb begin : exec_logic
		busy_c      = thr_rdata.inq || (cv_q && cur_q == ev_tid_q);
		st_c        = pts_pkg::RS_DONE;
		thr_we_c    = 1'b0;
		thr_wa_c    = ev_tid_q;
		thr_wd_c    = thr_rdata;
		push_c      = 1'b0;
		push_tid_c  = ev_tid_q;
		push_prio_c = thr_rdata.prio;
		disp_c      = 1'b0;
		tick_dec_c  = 1'b0;
		cur_e.status = cur_status_q;
		cur_e.prio   = cur_prio_q;
		cur_e.sig    = cur_sig_q;
		cur_e.inq    = 1'b1;
		unique case (ev_mode_q)
			pts_pkg::MODE_CREATE: begin
				if (busy_c) begin
					st_c = pts_pkg::RS_BUSY;
				end else begin
					thr_we_c        = 1'b1;
					thr_wd_c.status = pts_pkg::TS_RUN;
					thr_wd_c.prio   = ev_prio_q;
					thr_wd_c.sig    = 1'b0;
					thr_wd_c.inq    = ev_run_q;
					push_c          = ev_run_q;
					push_prio_c     = ev_prio_q;
				end
			end
			pts_pkg::MODE_ENQUEUE: begin
				if (busy_c) begin
					st_c = pts_pkg::RS_BUSY;
				end else begin
					thr_we_c     = 1'b1;
					thr_wd_c.inq = 1'b1;
					push_c       = 1'b1;
				end
			end
			pts_pkg::MODE_TICK: begin
				if (cv_q) begin
					if (ticks_q < pts_pkg::QUANT_W'(2)) begin
						thr_we_c    = 1'b1;
						thr_wa_c    = cur_q;
						thr_wd_c    = cur_e;
						push_c      = 1'b1;
						push_tid_c  = cur_q;
						push_prio_c = cur_prio_q;
						disp_c      = 1'b1;
					end else begin
						tick_dec_c = 1'b1;
					end
				end
			end
			pts_pkg::MODE_YIELD: begin
				if (cv_q) begin
					if (cur_status_q == pts_pkg::TS_RUN) begin
						thr_we_c    = 1'b1;
						thr_wa_c    = cur_q;
						thr_wd_c    = cur_e;
						push_c      = 1'b1;
						push_tid_c  = cur_q;
						push_prio_c = cur_prio_q;
					end
					disp_c = 1'b1;
				end
			end
			pts_pkg::MODE_BLOCK: begin
				if (cv_q) begin
					thr_we_c        = 1'b1;
					thr_wa_c        = cur_q;
					thr_wd_c        = cur_e;
					thr_wd_c.status = ev_intr_q ? pts_pkg::TS_BLKI : pts_pkg::TS_BLK;
					thr_wd_c.inq    = 1'b0;
					disp_c          = 1'b1;
				end
			end
			pts_pkg::MODE_SIGNAL: begin
				if (thr_rdata.status != pts_pkg::TS_BLK &&
						thr_rdata.status != pts_pkg::TS_BLKI) begin
					st_c = pts_pkg::RS_IGNORED;
				end else if (thr_rdata.status == pts_pkg::TS_BLK && ev_sig_q) begin
					st_c = pts_pkg::RS_IGNORED;
				end else if (busy_c) begin
					st_c = pts_pkg::RS_BUSY;
				end else begin
					thr_we_c        = 1'b1;
					thr_wd_c.status = pts_pkg::TS_RUN;
					thr_wd_c.sig    = ev_sig_q;
					thr_wd_c.inq    = 1'b1;
					push_c          = 1'b1;
				end
			end
			pts_pkg::MODE_EXIT: begin
				if (cv_q) begin
					thr_we_c        = 1'b1;
					thr_wa_c        = cur_q;
					thr_wd_c        = cur_e;
					thr_wd_c.status = pts_pkg::TS_DEAD;
					thr_wd_c.inq    = 1'b0;
					disp_c          = 1'b1;
				end
			end
			default: begin
				st_c = pts_pkg::RS_IGNORED;
			end
		endcase
		// a thread made ready while idle runs at once
		if (st_c == pts_pkg::RS_DONE && !cv_q && push_c) begin
			disp_c = 1'b1;
		end
	end

	always_comb begin : queue_logic
		push_lv   = pts_pkg::lvl_t'(push_prio_c);
		ne_n      = ne_q;
		head_n    = head_q;
		tail_n    = tail_q;
		link_we_c = 1'b0;
		link_wa_c = tail_q[push_lv];
		if (push_c) begin
			if (ne_q[push_lv]) begin
				link_we_c = 1'b1;
			end else begin
				head_n[push_lv] = push_tid_c;
			end
			tail_n[push_lv] = push_tid_c;
			ne_n[push_lv]   = 1'b1;
		end
		sel_lv = '0;
		for (int i = pts_pkg::LEVELS - 1; i >= 0; i--) begin
			if (ne_n[i]) begin
				sel_lv = pts_pkg::lvl_t'(i);
			end
		end
		sel_head = head_n[sel_lv];
		disp_ok  = disp_c && (|ne_n);
		cv_fin   = disp_c ? 1'b0 : cv_q;
		st_fin   = (st_c == pts_pkg::RS_DONE && !cv_fin) ? pts_pkg::RS_IDLE : st_c;
		disp_e    = fwd_thr_q ? fwd_thr_val_q : thr_rdata;
		disp_next = fwd_link_q ? fwd_link_val_q : link_rdata;
	end

	always_comb begin : fsm_next
		state_n = state_q;
		unique case (state_q)
			pts_pkg::FSM_IDLE: begin
				if (s_tvalid) begin
					state_n = pts_pkg::FSM_EXEC;
				end
			end
			pts_pkg::FSM_EXEC: begin
				if (out_free) begin
					state_n = disp_ok ? pts_pkg::FSM_DISP : pts_pkg::FSM_IDLE;
				end
			end
			pts_pkg::FSM_DISP: begin
				if (out_free) begin
					state_n = pts_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_n = pts_pkg::FSM_IDLE;
			end
		endcase
	end

	always_comb begin : fsm_out
		s_tready = 1'b0;
		exec_go  = 1'b0;
		disp_go  = 1'b0;
		unique case (state_q)
			pts_pkg::FSM_IDLE: s_tready = 1'b1;
			pts_pkg::FSM_EXEC: exec_go  = out_free;
			pts_pkg::FSM_DISP: disp_go  = out_free;
			default: s_tready = 1'b0;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_comb begin : mem_ports
		thr_req.rd_en   = 1'b0;
		thr_req.rd_addr = s_tdata[pts_pkg::TID_W-1:0];
		thr_req.wr_en   = 1'b0;
		thr_req.wr_addr = thr_wa_c;
		thr_req.wr_data = thr_wd_c;
		link_req.rd_en   = exec_go && disp_ok;
		link_req.rd_addr = sel_head;
		link_req.wr_en   = exec_go && link_we_c;
		link_req.wr_addr = link_wa_c;
		link_req.wr_data = push_tid_c;
		if (accept) begin
			thr_req.rd_en = 1'b1;
		end else if (exec_go) begin
			thr_req.rd_en   = disp_ok;
			thr_req.rd_addr = sel_head;
			thr_req.wr_en   = thr_we_c;
		end else if (disp_go) begin
			thr_req.wr_en       = 1'b1;
			thr_req.wr_addr     = dh_q;
			thr_req.wr_data     = disp_e;
			thr_req.wr_data.inq = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_mode_q <= s_tuser;
			ev_tid_q  <= s_tdata[pts_pkg::TID_W-1:0];
			ev_prio_q <= prio_in;
			ev_run_q  <= s_tdata[8];
			ev_intr_q <= s_tdata[9];
			ev_sig_q  <= s_tdata[10];
		end
		if (exec_go) begin
			dlv_q          <= sel_lv;
			dh_q           <= sel_head;
			fwd_link_q     <= link_we_c && (link_wa_c == sel_head);
			fwd_link_val_q <= push_tid_c;
			fwd_thr_q      <= thr_we_c && (thr_wa_c == sel_head);
			fwd_thr_val_q  <= thr_wd_c;
		end
		if (exec_go && !disp_ok) begin
			out_thread_q <= cv_fin ? cur_q : '0;
			out_run_q    <= cv_fin;
			out_sw_q     <= 1'b0;
			out_status_q <= st_fin;
			out_sig_q    <= cv_fin && cur_sig_q;
		end else if (disp_go) begin
			out_thread_q <= dh_q;
			out_run_q    <= 1'b1;
			out_sw_q     <= 1'b1;
			out_status_q <= pts_pkg::RS_DONE;
			out_sig_q    <= disp_e.sig;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pts_pkg::FSM_IDLE;
			cur_q        <= '0;
			cv_q         <= 1'b1;
			cur_status_q <= pts_pkg::TS_RUN;
			cur_prio_q   <= pts_pkg::PRIO_THREAD0;
			cur_sig_q    <= 1'b0;
			ticks_q      <= pts_pkg::QUANTUM_RESET;
			quantum_q    <= pts_pkg::QUANTUM_RESET;
			head_q       <= '{default: '0};
			tail_q       <= '{default: '0};
			ne_q         <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_wr_en) begin
				quantum_q <= cfg_wr_data;
			end
			if (exec_go) begin
				ne_q   <= ne_n;
				head_q <= head_n;
				tail_q <= tail_n;
				if (tick_dec_c) begin
					ticks_q <= ticks_q - 1'b1;
				end
				if (disp_c && !disp_ok) begin
					cv_q <= 1'b0;
				end
			end
			if (disp_go) begin
				// pop the head; the queue empties when head meets tail
				if (dh_q == tail_q[dlv_q]) begin
					ne_q[dlv_q] <= 1'b0;
				end else begin
					head_q[dlv_q] <= disp_next;
				end
				cur_q        <= dh_q;
				cv_q         <= 1'b1;
				cur_status_q <= disp_e.status;
				cur_prio_q   <= disp_e.prio;
				cur_sig_q    <= disp_e.sig;
				ticks_q      <= quantum_q;
			end
			if ((exec_go && !disp_ok) || disp_go) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, out_sig_q, out_status_q, out_sw_q, out_run_q, out_thread_q};

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pts_pkg::FSM_IDLE && !cv_q) |-> (ne_q == '0))
		else $error("idle with a non-empty ready queue");

	a_disp_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pts_pkg::FSM_DISP && $past(state_q) != pts_pkg::FSM_DISP)
			|-> ($past(state_q) == pts_pkg::FSM_EXEC))
		else $error("dispatch cycle not preceded by event cycle");

	a_switch_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_sw_q) |-> (out_run_q && out_status_q == pts_pkg::RS_DONE))
		else $error("switch reported without a running thread");

endmodule

// File: rtl/pts_store.sv
module pts_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pts_pkg::thr_req_t      thr_req,
	output pts_pkg::thr_entry_t    thr_rdata,
	input  pts_pkg::link_req_t     link_req,
	output pts_pkg::tid_t          link_rdata
);

	pts_pkg::thr_entry_t thr_mem [pts_pkg::THREADS];
	pts_pkg::tid_t link_mem [pts_pkg::THREADS];
	logic [pts_pkg::THREADS-1:0] thr_vld_q;
	pts_pkg::thr_entry_t thr_rd_q;
	pts_pkg::tid_t link_rd_q;
	logic thr_hit_q;
	logic thr_zero_q;

	always_ff @(posedge clk) begin
		if (thr_req.wr_en) begin
			thr_mem[thr_req.wr_addr] <= thr_req.wr_data;
		end
		if (thr_req.rd_en) begin
			thr_rd_q <= thr_mem[thr_req.rd_addr];
		end
		if (link_req.wr_en) begin
			link_mem[link_req.wr_addr] <= link_req.wr_data;
		end
		if (link_req.rd_en) begin
			link_rd_q <= link_mem[link_req.rd_addr];
		end
	end

	// entries never written read as their reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_vld_q  <= '0;
			thr_hit_q  <= 1'b0;
			thr_zero_q <= 1'b0;
		end else begin
			if (thr_req.wr_en) begin
				thr_vld_q[thr_req.wr_addr] <= 1'b1;
			end
			if (thr_req.rd_en) begin
				thr_hit_q  <= thr_vld_q[thr_req.rd_addr];
				thr_zero_q <= (thr_req.rd_addr == '0);
			end
		end
	end

	always_comb begin
		if (thr_hit_q) begin
			thr_rdata = thr_rd_q;
		end else begin
			thr_rdata.status = pts_pkg::TS_RUN;
			thr_rdata.prio   = thr_zero_q ? pts_pkg::PRIO_THREAD0 : '0;
			thr_rdata.sig    = 1'b0;
			thr_rdata.inq    = 1'b0;
		end
	end

	assign link_rdata = link_rd_q;

endmodule
